>>> src/roc_auc_accumulator_macros.svh
// Assertion macros for the ROC AUC accumulator.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef ROC_AUC_ACCUMULATOR_MACROS_SVH
`define ROC_AUC_ACCUMULATOR_MACROS_SVH

`ifndef SYNTHESIS

`define RAA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define RAA_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define RAA_ASSERT(label, prop)

`define RAA_NEVER(label, cond)

`endif

`endif

>>> src/roc_auc_pkg.sv
// Shared types for the ROC AUC accumulator.
// No dependencies.
`default_nettype none

package roc_auc_pkg;

    localparam int SCORE_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_ADD,
        ST_CLOSE,
        ST_CLOSE_ADD,
        ST_DEN,
        ST_DIV,
        ST_OUT
    } raa_state_t;

endpackage

`default_nettype wire

>>> src/roc_auc_accumulator.sv
// ROC AUC accumulator top level: sequencer around one shared multiplier.
// Depends on roc_auc_pkg and roc_auc_accumulator_macros.svh.
//
// Takes scored words sorted by descending score (score_first - score_second) and integrates
// the ROC curve by the trapezoidal rule, tied scores forming one point. One word at a time:
// each word is counted and, when its score closes a point, the point's area is multiplied,
// then accumulated, all through the single shared multiplier. The word marked tlast then
// closes the curve, forms P*N on the same multiplier (doubled to 2*P*N as divisor) and runs
// a restoring divide for the AUC_FRAC_BITS+1 quotient bits; a degenerate set skips the
// divide. The result sits in an output register until taken, so the next data set may start
// meanwhile; a second result waits in the sequencer with the input stalled. The counts,
// points and area clear for the next data set. Words beyond MAX_ITEMS are not counted.
// Output auc is truncated Q1.AUC_FRAC_BITS; degenerate (tuser) is set with auc zero when
// either count is zero.
`default_nettype none
`include "roc_auc_accumulator_macros.svh"

module roc_auc_accumulator #(
    parameter int MAX_ITEMS     = 1048576,
    parameter int AUC_FRAC_BITS = 16,
    localparam int CNT_W        = $clog2(MAX_ITEMS + 1),
    localparam int AUC_W        = AUC_FRAC_BITS + 1,
    localparam int OUT_W        = ((AUC_W + 2 * CNT_W + 7) / 8) * 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [31:0] score_first, [63:32] score_second
    input  wire logic [2*roc_auc_pkg::SCORE_W-1:0]   s_tdata,
    // [0] is_positive
    input  wire logic                                s_tuser,
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // auc, positives, negatives from the lowest bit up, zero padded
    output logic [OUT_W-1:0]                         m_tdata,
    // [0] degenerate
    output logic                                     m_tuser
);

    import roc_auc_pkg::*;

    localparam int AREA_W = 2 * CNT_W + 1;
    localparam int DIFF_W = SCORE_W + 1;
    localparam int STEP_W = $clog2(AUC_FRAC_BITS + 1);
    localparam logic [CNT_W:0]    MAX_L     = (CNT_W + 1)'(MAX_ITEMS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(AUC_FRAC_BITS);

    raa_state_t state_reg, state_next;

    logic [CNT_W-1:0]  pos_count_reg, pos_count_next;
    logic [CNT_W-1:0]  neg_count_reg, neg_count_next;
    logic [CNT_W-1:0]  pos_at_reg, pos_at_next;
    logic [CNT_W-1:0]  neg_at_reg, neg_at_next;
    logic [CNT_W-1:0]  pos_last_reg, pos_last_next;
    logic [CNT_W-1:0]  neg_last_reg, neg_last_next;
    logic [DIFF_W-1:0] prev_score_reg, prev_score_next;
    logic              has_prev_reg, has_prev_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic [DIFF_W-1:0] score_reg, score_next;
    logic              positive_reg, positive_next;
    logic              last_reg, last_next;
    logic [AREA_W-1:0] mul_reg, mul_next;
    logic [AREA_W-1:0] rem_reg, rem_next;
    logic [AUC_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              degen_reg, degen_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;
    logic              out_degen_reg, out_degen_next;

    logic              s_accept;
    logic              out_free;
    logic              room;
    logic              count_close;
    logic              degen_now;
    logic [CNT_W-1:0]  pos_inc;
    logic [CNT_W-1:0]  neg_inc;
    logic [CNT_W-1:0]  mul_a;
    logic [CNT_W:0]    mul_b;
    logic [AREA_W-1:0] mul_prod;
    logic [AREA_W:0]   trial;
    logic [AREA_W:0]   den_ext;
    logic              fits;

    assign s_accept    = s_tvalid && s_tready;
    assign out_free    = !out_valid_reg || m_tready;
    assign room        = ({1'b0, pos_count_reg} + {1'b0, neg_count_reg}) < MAX_L;
    assign count_close = room && (!has_prev_reg || (score_reg != prev_score_reg));
    assign degen_now   = (pos_count_reg == '0) || (neg_count_reg == '0);
    assign pos_inc     = positive_reg ? pos_count_reg + 1'b1 : pos_count_reg;
    assign neg_inc     = positive_reg ? neg_count_reg : neg_count_reg + 1'b1;
    assign mul_prod    = AREA_W'(mul_a) * AREA_W'(mul_b);
    assign trial       = (step_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign den_ext     = {mul_reg, 1'b0};
    assign fits        = trial >= den_ext;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (count_close)
                begin
                    state_next = ST_ADD;
                end
                else if (last_reg)
                begin
                    state_next = ST_CLOSE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADD:
            begin
                state_next = last_reg ? ST_CLOSE : ST_IDLE;
            end
            ST_CLOSE:
            begin
                state_next = has_prev_reg ? ST_CLOSE_ADD : ST_DEN;
            end
            ST_CLOSE_ADD:
            begin
                state_next = ST_DEN;
            end
            ST_DEN:
            begin
                state_next = degen_now ? ST_OUT : ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = out_valid_reg;
        m_tdata  = out_data_reg;
        m_tuser  = out_degen_reg;
        if (state_reg == ST_DEN)
        begin
            mul_a = neg_count_reg;
            mul_b = {1'b0, pos_count_reg};
        end
        else
        begin
            mul_a = neg_at_reg - neg_last_reg;
            mul_b = {1'b0, pos_at_reg} + {1'b0, pos_last_reg};
        end
    end

    always_comb
    begin
        pos_count_next  = pos_count_reg;
        neg_count_next  = neg_count_reg;
        pos_at_next     = pos_at_reg;
        neg_at_next     = neg_at_reg;
        pos_last_next   = pos_last_reg;
        neg_last_next   = neg_last_reg;
        prev_score_next = prev_score_reg;
        has_prev_next   = has_prev_reg;
        area_next       = area_reg;
        score_next      = score_reg;
        positive_next   = positive_reg;
        last_next       = last_reg;
        mul_next        = mul_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        degen_next      = degen_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_degen_next  = out_degen_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    score_next    = {s_tdata[SCORE_W-1], s_tdata[SCORE_W-1:0]}
                                  - {s_tdata[2*SCORE_W-1], s_tdata[2*SCORE_W-1:SCORE_W]};
                    positive_next = s_tuser;
                    last_next     = s_tlast;
                end
            end
            ST_COUNT:
            begin
                if (room)
                begin
                    pos_count_next  = pos_inc;
                    neg_count_next  = neg_inc;
                    pos_at_next     = pos_inc;
                    neg_at_next     = neg_inc;
                    prev_score_next = score_reg;
                    has_prev_next   = 1'b1;
                    if (count_close)
                    begin
                        mul_next      = mul_prod;
                        pos_last_next = pos_at_reg;
                        neg_last_next = neg_at_reg;
                    end
                end
            end
            ST_ADD, ST_CLOSE_ADD:
            begin
                area_next = area_reg + mul_reg;
            end
            ST_CLOSE:
            begin
                if (has_prev_reg)
                begin
                    mul_next      = mul_prod;
                    pos_last_next = pos_at_reg;
                    neg_last_next = neg_at_reg;
                end
            end
            ST_DEN:
            begin
                mul_next   = mul_prod;
                rem_next   = area_reg;
                quo_next   = '0;
                step_next  = '0;
                degen_next = degen_now;
            end
            ST_DIV:
            begin
                rem_next  = fits ? AREA_W'(trial - den_ext) : AREA_W'(trial);
                quo_next  = {quo_reg[AUC_W-2:0], fits};
                step_next = step_reg + 1'b1;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = OUT_W'({neg_count_reg, pos_count_reg,
                                              degen_reg ? AUC_W'(0) : quo_reg});
                    out_degen_next  = degen_reg;
                    pos_count_next  = '0;
                    neg_count_next  = '0;
                    pos_at_next     = '0;
                    neg_at_next     = '0;
                    pos_last_next   = '0;
                    neg_last_next   = '0;
                    prev_score_next = '0;
                    has_prev_next   = 1'b0;
                    area_next       = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_count_reg  <= '0;
            neg_count_reg  <= '0;
            pos_at_reg     <= '0;
            neg_at_reg     <= '0;
            pos_last_reg   <= '0;
            neg_last_reg   <= '0;
            prev_score_reg <= '0;
            has_prev_reg   <= 1'b0;
            area_reg       <= '0;
            degen_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_degen_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_count_reg  <= pos_count_next;
            neg_count_reg  <= neg_count_next;
            pos_at_reg     <= pos_at_next;
            neg_at_reg     <= neg_at_next;
            pos_last_reg   <= pos_last_next;
            neg_last_reg   <= neg_last_next;
            prev_score_reg <= prev_score_next;
            has_prev_reg   <= has_prev_next;
            area_reg       <= area_next;
            degen_reg      <= degen_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            out_degen_reg  <= out_degen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg    <= score_next;
        positive_reg <= positive_next;
        last_reg     <= last_next;
        mul_reg      <= mul_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
    end

    `RAA_NEVER(a_div_overrun, (state_reg == ST_DIV) && (step_reg > LAST_STEP))
    `RAA_ASSERT(a_count_cap, ({1'b0, pos_count_reg} + {1'b0, neg_count_reg}) <= MAX_L)
    `RAA_ASSERT(a_degen_zero, m_tvalid && m_tuser |-> m_tdata[AUC_W-1:0] == '0)
    `RAA_ASSERT(a_auc_bound, m_tvalid && !m_tuser |-> m_tdata[AUC_W-1:0] <= (AUC_W'(1) << AUC_FRAC_BITS))
    `RAA_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `RAA_ASSERT(a_clear_after_out, (state_reg == ST_OUT) && out_free |=> (pos_count_reg == '0)
        && (neg_count_reg == '0) && !has_prev_reg && (area_reg == '0))

endmodule

`default_nettype wire

>>> test/roc_auc_accumulator_test.sv
// Self-checking bench for roc_auc_accumulator: directed table, then random scored data sets.
// Depends on roc_auc_pkg and the RTL of roc_auc_accumulator; expectations come from a
// behavioural tracker of the trapezoidal AUC built into this file, or from typed table rows.
`default_nettype none

module roc_auc_accumulator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  AUC_W        = 17;
    localparam int  CNT_W        = 21;
    localparam int  OUT_W        = 64;
    localparam int  FRAC_BITS    = 16;
    localparam longint unsigned CAPACITY = 1048576;
    localparam int  RANDOM_WORDS = 1900;
    localparam int  HOLD_OFF     = 400;
    localparam int  HOLD_AT      = 40;
    localparam int  DRAIN        = 40;
    localparam int  LIMIT        = 500000;
    localparam longint SCORE_MAX = 64'sd4294967295;
    localparam longint SCORE_MIN = -64'sd4294967295;
    localparam int  MAX_REPORTS  = 10;

    typedef struct {
        logic [AUC_W-1:0] auc;
        logic [CNT_W-1:0] positives;
        logic [CNT_W-1:0] negatives;
        logic             degenerate;
    } auc_result_t;

    typedef struct packed {
        logic [31:0]      first;
        logic [31:0]      second;
        logic             positive;
        logic             last;
        logic             typed;
        logic [AUC_W-1:0] auc;
        logic [CNT_W-1:0] positives;
        logic [CNT_W-1:0] negatives;
        logic             degenerate;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    // [31:0] score_first, [63:32] score_second
    logic [2*roc_auc_pkg::SCORE_W-1:0] s_tdata;
    // [0] is_positive
    logic s_tuser;
    logic s_tlast;
    logic m_tvalid;
    logic m_tready;
    // [16:0] auc, [37:17] positives, [58:38] negatives, [63:59] zero
    logic [OUT_W-1:0] m_tdata;
    // [0] degenerate
    logic m_tuser;

    roc_auc_accumulator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    longint unsigned cnt_pos;
    longint unsigned cnt_neg;
    longint unsigned grp_pos;
    longint unsigned grp_neg;
    longint unsigned vtx_pos;
    longint unsigned vtx_neg;
    longint unsigned twice_area;
    longint          last_score;
    bit              score_valid;

    auc_result_t auc_due[$];
    stim_row_t   plan[0:21];
    int          mismatches;
    int          results_seen;
    bit          sender_quiet;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    function automatic stim_row_t stim_row(input logic [31:0] first, input logic [31:0] second,
                                           input logic positive, input logic last,
                                           input logic typed, input int auc, input int pos,
                                           input int neg, input logic degenerate);
        stim_row_t r;
        r.first      = first;
        r.second     = second;
        r.positive   = positive;
        r.last       = last;
        r.typed      = typed;
        r.auc        = AUC_W'(auc);
        r.positives  = CNT_W'(pos);
        r.negatives  = CNT_W'(neg);
        r.degenerate = degenerate;
        return r;
    endfunction

    task automatic clear_tracker;
        cnt_pos     = 0;
        cnt_neg     = 0;
        grp_pos     = 0;
        grp_neg     = 0;
        vtx_pos     = 0;
        vtx_neg     = 0;
        twice_area  = 0;
        last_score  = 0;
        score_valid = 1'b0;
    endtask

    task automatic close_vertex;
        twice_area = twice_area + (grp_neg - vtx_neg) * (grp_pos + vtx_pos);
        vtx_neg    = grp_neg;
        vtx_pos    = grp_pos;
    endtask

    task automatic roc_track(input logic [31:0] first, input logic [31:0] second,
                             input logic positive, input logic last,
                             output bit produced, output auc_result_t r);
        int              fi;
        int              si;
        longint          score;
        longint unsigned den;
        longint unsigned quo;
        fi = first;
        si = second;
        score = longint'(fi) - longint'(si);
        produced     = 1'b0;
        r.auc        = '0;
        r.positives  = '0;
        r.negatives  = '0;
        r.degenerate = 1'b0;
        if (cnt_pos + cnt_neg < CAPACITY)
        begin
            if (positive)
                cnt_pos = cnt_pos + 1;
            else
                cnt_neg = cnt_neg + 1;
            if (!score_valid || score != last_score)
                close_vertex();
            grp_pos     = cnt_pos;
            grp_neg     = cnt_neg;
            last_score  = score;
            score_valid = 1'b1;
        end
        if (last)
        begin
            if (score_valid)
                close_vertex();
            r.degenerate = (cnt_pos == 0) || (cnt_neg == 0);
            if (!r.degenerate)
            begin
                den   = 2 * cnt_pos * cnt_neg;
                quo   = (twice_area << FRAC_BITS) / den;
                r.auc = quo[AUC_W-1:0];
            end
            r.positives = cnt_pos[CNT_W-1:0];
            r.negatives = cnt_neg[CNT_W-1:0];
            produced    = 1'b1;
            clear_tracker();
        end
    endtask

    task automatic send_word(input stim_row_t row);
        int          gap;
        bit          produced;
        auc_result_t r;
        gap = sender_quiet ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {row.second, row.first};
        s_tuser  <= row.positive;
        s_tlast  <= row.last;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        roc_track(row.first, row.second, row.positive, row.last, produced, r);
        if (produced)
        begin
            if (row.typed)
            begin
                r.auc        = row.auc;
                r.positives  = row.positives;
                r.negatives  = row.negatives;
                r.degenerate = row.degenerate;
            end
            auc_due.push_back(r);
        end
    endtask

    function automatic stim_row_t scored_row(input longint score, input logic positive,
                                             input logic last);
        longint          lo;
        longint          hi;
        longint unsigned span;
        longint unsigned pick;
        longint          second;
        longint          first;
        if (score >= 0)
        begin
            lo = -64'sd2147483648;
            hi = 64'sd2147483647 - score;
        end
        else
        begin
            lo = -64'sd2147483648 - score;
            hi = 64'sd2147483647;
        end
        span   = longint'(hi - lo + 1);
        pick   = {$urandom, $urandom};
        pick   = pick % span;
        second = lo + longint'(pick);
        first  = score + second;
        return stim_row(first[31:0], second[31:0], positive, last, 1'b0, 0, 0, 0, 1'b0);
    endfunction

    // receiver: random back-pressure, one long hold-off, compare against the oldest expectation
    initial
    begin
        int  wait_cycles;
        bit  rx_quiet;
        auc_result_t e;
        logic [AUC_W-1:0] got_auc;
        logic [CNT_W-1:0] got_pos;
        logic [CNT_W-1:0] got_neg;
        logic [4:0]       got_pad;
        m_tready = 1'b0;
        rx_quiet = 1'b0;
        results_seen = 0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                rx_quiet = ~rx_quiet;
            wait_cycles = rx_quiet ? 0 : $urandom_range(0, 7);
            if (results_seen == HOLD_AT)
                wait_cycles = HOLD_OFF;
            @(negedge clk);
            if (wait_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            results_seen = results_seen + 1;
            got_auc = m_tdata[16:0];
            got_pos = m_tdata[37:17];
            got_neg = m_tdata[58:38];
            got_pad = m_tdata[63:59];
            if (auc_due.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result word: auc %0d pos %0d neg %0d degenerate %0b",
                             got_auc, got_pos, got_neg, m_tuser);
            end
            else
            begin
                e = auc_due.pop_front();
                if (got_auc !== e.auc || got_pos !== e.positives || got_neg !== e.negatives
                    || m_tuser !== e.degenerate || got_pad !== 5'd0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("result %0d expected: auc %0d pos %0d neg %0d degen %0b",
                                 results_seen, e.auc, e.positives, e.negatives, e.degenerate);
                        $display("result %0d actual: auc %0d pos %0d neg %0d degen %0b pad %0h",
                                 results_seen, got_auc, got_pos, got_neg, m_tuser, got_pad);
                    end
                end
            end
        end
    end

    initial
    begin
        int     words_sent;
        int     len;
        int     mode;
        int     hi_pct;
        int     lo_pct;
        int     pos_pct;
        int     step_pick;
        longint score;
        longint step;
        logic   positive;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        s_tlast      = 1'b0;
        mismatches   = 0;
        sender_quiet = 1'b0;
        clear_tracker();

        plan[0]  = stim_row(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 0, 1, 0, 1'b1);
        plan[1]  = stim_row(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 0, 0, 1, 1'b1);
        plan[2]  = stim_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        plan[3]  = stim_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 65536, 1, 1, 1'b0);
        plan[4]  = stim_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        plan[5]  = stim_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 1'b1, 0, 1, 1, 1'b0);
        plan[6]  = stim_row(32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        plan[7]  = stim_row(32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1, 1'b1, 32768, 1, 1, 1'b0);
        plan[8]  = stim_row(32'h0003_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        plan[9]  = stim_row(32'h0002_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        plan[10] = stim_row(32'h0001_0000, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 0, 3, 0, 1'b1);
        plan[11] = stim_row(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        plan[12] = stim_row(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 0, 0, 2, 1'b1);
        plan[13] = stim_row(32'h0005_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        plan[14] = stim_row(32'h0004_0000, 32'hFFFF_0000, 1'b0, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        plan[15] = stim_row(32'h0003_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        plan[16] = stim_row(32'h0002_0000, 32'hFFFF_0000, 1'b0, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        plan[17] = stim_row(32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        plan[18] = stim_row(32'h8000_0001, 32'h0000_0001, 1'b0, 1'b1, 1'b0, 0, 0, 0, 1'b0);
        plan[19] = stim_row(32'h0000_0010, 32'h0000_0020, 1'b0, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        plan[20] = stim_row(32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        plan[21] = stim_row(32'h0000_0010, 32'h0000_0020, 1'b1, 1'b1, 1'b0, 0, 0, 0, 1'b0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 22; i++)
            send_word(plan[i]);

        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            len  = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 250) : $urandom_range(1, 16);
            mode = $urandom_range(0, 9);
            hi_pct = $urandom_range(0, 100);
            lo_pct = $urandom_range(0, 100);
            sender_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0)
                score = SCORE_MAX;
            else
                score = SCORE_MIN + longint'({$urandom, $urandom} % 64'd8589934591);
            for (int i = 0; i < len; i++)
            begin
                pos_pct  = hi_pct - ((hi_pct - lo_pct) * i) / len;
                positive = ($urandom_range(0, 99) < pos_pct);
                if (mode == 9)
                begin
                    send_word(stim_row($urandom, $urandom, positive, i == len - 1,
                                       1'b0, 0, 0, 0, 1'b0));
                end
                else
                begin
                    if (mode == 8)
                        score = longint'($urandom_range(0, 7)) - 4;
                    else if (i > 0)
                    begin
                        step_pick = $urandom_range(0, 9);
                        if (step_pick < 3 || (mode == 7 && step_pick < 7))
                            step = 0;
                        else if (step_pick < 8)
                            step = longint'($urandom_range(1, 4096));
                        else
                            step = longint'($urandom);
                        score = score - step;
                        if (score < SCORE_MIN)
                            score = SCORE_MIN;
                    end
                    send_word(scored_row(score, positive, i == len - 1));
                end
                words_sent = words_sent + 1;
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (auc_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (mismatches == 0 && auc_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
